### sv/xbr_pkg.sv
`default_nettype none

package xbr_pkg;

	// Line control codes
	localparam logic [7:0] CODE_SOH = 8'h01;
	localparam logic [7:0] CODE_EOT = 8'h04;
	localparam logic [7:0] CODE_ACK = 8'h06;
	localparam logic [7:0] CODE_NAK = 8'h15;

	// Default payload length of one block
	localparam int DATA_BYTES_DEF = 5;

	// Jobs held between front and back
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic REG_PAD_BYTE      = 1'b0;
	localparam logic REG_STRIP_PADDING = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0] PAD_BYTE_RST      = 8'h03;
	localparam logic       STRIP_PADDING_RST = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_NAK  = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	// Receive phases of the front end
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_NUM  = 3'd1,
		PH_CMP  = 3'd2,
		PH_DATA = 3'd3,
		PH_SUM  = 3'd4
	} phase_t;

	// One job: reply kind and, for a good block, the payload bank to deliver
	typedef struct packed {
		kind_t kind;
		logic  bank;
	} job_t;

	// Back end hands a payload bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_release_t;

endpackage

`default_nettype wire

### sv/xbr_front.sv
`default_nettype none

module xbr_front
	import xbr_pkg::*;
#(
	parameter int DATA_BYTES = DATA_BYTES_DEF,
	localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          rx_byte,
	output logic                     push_valid,
	output job_t                     push_job,
	input  wire logic                q_ready,
	input  bank_release_t            rel,
	output logic                     wr_en,
	output logic [IDX_W:0]           wr_addr,
	output logic [7:0]               wr_data
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_BYTES - 1);

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       num_q;
	logic [7:0]       cmp_q;
	logic             wr_bank_q;
	logic [1:0]       busy_q;
	logic             accept;
	logic             block_bad;

	// Hold off all bytes while the job queue is full, and payload bytes while the bank being filled is still in use
	assign in_ready  = q_ready && !(phase_q == PH_DATA && busy_q[wr_bank_q]);
	assign accept    = in_valid && in_ready;
	assign block_bad = ((~num_q) != cmp_q) || (sum_q != rx_byte);

	assign wr_addr = {wr_bank_q, idx_q};
	assign wr_data = rx_byte;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: if (rx_byte == CODE_SOH) phase_d = PH_NUM;
				PH_NUM:  phase_d = PH_CMP;
				PH_CMP:  phase_d = PH_DATA;
				PH_DATA: if (idx_q == IDX_LAST) phase_d = PH_SUM;
				PH_SUM:  phase_d = PH_HUNT;
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Job pushes and payload writes
	always_comb begin
		push_valid    = 1'b0;
		push_job.kind = KIND_END;
		push_job.bank = wr_bank_q;
		wr_en         = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == CODE_EOT) begin
						push_valid    = 1'b1;
						push_job.kind = KIND_END;
					end
				end
				PH_DATA: wr_en = 1'b1;
				PH_SUM: begin
					push_valid    = 1'b1;
					push_job.kind = block_bad ? KIND_NAK : KIND_ACK;
				end
				default: ;
			endcase
		end
	end

	// Phase, counter and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == PH_CMP) begin
				idx_q <= '0;
				sum_q <= '0;
			end else if (accept && phase_q == PH_DATA) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	// Block number and its complement
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_NUM) num_q <= rx_byte;
		if (accept && phase_q == PH_CMP) cmp_q <= rx_byte;
	end

	// Payload bank ownership: a good block hands its bank to the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= 1'b0;
			busy_q    <= '0;
		end else begin
			if (push_valid && push_job.kind == KIND_ACK) begin
				wr_bank_q         <= ~wr_bank_q;
				busy_q[wr_bank_q] <= 1'b1;
			end
			if (rel.valid) busy_q[rel.bank] <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### sv/xbr_job_queue.sv
`default_nettype none

module xbr_job_queue
	import xbr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	input  job_t      push_job,
	output logic      push_ready,
	output logic      pop_valid,
	output job_t      pop_job,
	input  wire logic pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entries
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

### sv/xbr_back.sv
`default_nettype none

module xbr_back
	import xbr_pkg::*;
#(
	parameter int DATA_BYTES = DATA_BYTES_DEF,
	localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  job_t                     q_job,
	output logic                     q_pop,
	output bank_release_t            rel,
	input  wire logic                wr_en,
	input  wire logic [IDX_W:0]      wr_addr,
	input  wire logic [7:0]          wr_data,
	input  wire logic [7:0]          pad_byte,
	input  wire logic                strip_padding,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kind_t                    out_kind,
	output logic [7:0]               out_byte,
	output logic                     last
);

	localparam int CNT_W     = $clog2(DATA_BYTES + 1);
	localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

	logic [7:0]       mem [MEM_DEPTH];

	logic             act_q;
	logic             bank_q;
	logic [CNT_W-1:0] idx_q;
	logic             valid_s1;
	kind_t            kind_s1;
	logic [7:0]       rd_data_s1;
	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [7:0]       out_byte_q;
	logic             last_q;

	logic             out_free;
	logic             drop_s1;
	logic             s1_take;
	logic             s1_adv;
	logic             data_done;
	logic             iss_valid;
	kind_t            iss_kind;
	logic             rd_en;
	logic             start;
	logic [7:0]       byte_s1;

	assign out_free  = !out_valid_q || out_ready;
	assign drop_s1   = (kind_s1 == KIND_DATA) && strip_padding && (rd_data_s1 == pad_byte);
	assign s1_take   = valid_s1 && (drop_s1 || out_free);
	assign s1_adv    = !valid_s1 || s1_take;
	assign data_done = idx_q == CNT_W'(DATA_BYTES);

	// Issue: payload reads of an active block, then its ACK; other jobs go straight on
	always_comb begin
		iss_valid = 1'b0;
		iss_kind  = KIND_ACK;
		rd_en     = 1'b0;
		q_pop     = 1'b0;
		start     = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = bank_q;
		if (act_q) begin
			iss_valid = 1'b1;
			if (data_done) begin
				iss_kind  = KIND_ACK;
				rel.valid = s1_adv;
			end else begin
				iss_kind = KIND_DATA;
				rd_en    = s1_adv;
			end
		end else if (q_valid) begin
			if (q_job.kind == KIND_ACK) begin
				q_pop = 1'b1;
				start = 1'b1;
			end else begin
				iss_valid = 1'b1;
				iss_kind  = q_job.kind;
				q_pop     = s1_adv;
			end
		end
	end

	// Block walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			act_q <= 1'b1;
			idx_q <= '0;
		end else if (act_q) begin
			if (data_done && s1_adv) act_q <= 1'b0;
			else if (rd_en)         idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) bank_q <= q_job.bank;
	end

	// Payload memory, two banks of one block each
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= mem[{bank_q, idx_q[IDX_W-1:0]}];
	end

	// Read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= iss_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && iss_valid) kind_s1 <= iss_kind;
	end

	// Reply byte for each kind
	always_comb begin
		unique case (kind_s1)
			KIND_DATA: byte_s1 = rd_data_s1;
			KIND_NAK:  byte_s1 = CODE_NAK;
			default:   byte_s1 = CODE_ACK;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && !drop_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && !drop_s1) begin
			out_kind_q <= kind_s1;
			out_byte_q <= byte_s1;
			last_q     <= kind_s1 != KIND_DATA;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

`default_nettype wire

### sv/xmodem_block_receiver.sv
`default_nettype none

// XMODEM block receiver with additive checksum. Received bytes enter on the
// in channel at one byte per clock. While hunting, only SOH and EOT count; EOT
// answers with an end-of-transfer ACK. After SOH come the block number, its
// complement, DATA_BYTES payload bytes and the checksum byte. A bad block gives
// one NAK; a good one gives its payload bytes (bytes equal to pad_byte dropped
// when strip_padding is set) and then an ACK. The last result of each input
// byte has last set. Results leave through a registered output at up to one
// per clock while out_ready is high. A NAK or end ACK passes the job queue,
// the read stage and the output register; the first payload byte of a good
// block also waits for its block walk to start once its job leaves the queue.
// The front end keeps taking bytes while a block is delivered: payload sits in
// a two-bank memory and replies wait in a two-entry job queue; the input
// stalls when the job queue is full, or when a payload byte would go into a
// bank that is still being delivered. Write configuration only while the
// block is idle.
module xmodem_block_receiver
	import xbr_pkg::*;
#(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_kind,
	output logic [7:0]      out_byte,
	output logic            last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

	logic [7:0]     pad_byte_q;
	logic           strip_padding_q;

	logic           push_valid;
	job_t           push_job;
	logic           push_ready;
	logic           q_valid;
	job_t           q_job;
	logic           q_pop;
	bank_release_t  rel;
	logic           wr_en;
	logic [IDX_W:0] wr_addr;
	logic [7:0]     wr_data;
	kind_t          out_kind_w;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_byte_q      <= PAD_BYTE_RST;
			strip_padding_q <= STRIP_PADDING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAD_BYTE:      pad_byte_q      <= cfg_data;
				REG_STRIP_PADDING: strip_padding_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front end: framing, checksum, payload capture
	xbr_front #(
		.DATA_BYTES (DATA_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.push_valid (push_valid),
		.push_job   (push_job),
		.q_ready    (push_ready),
		.rel        (rel),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// Job queue between the two sides
	xbr_job_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_job    (q_job),
		.pop        (q_pop)
	);

	// Back end: payload delivery and replies
	xbr_back #(
		.DATA_BYTES (DATA_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_job         (q_job),
		.q_pop         (q_pop),
		.rel           (rel),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.pad_byte      (pad_byte_q),
		.strip_padding (strip_padding_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_kind      (out_kind_w),
		.out_byte      (out_byte),
		.last          (last)
	);

	assign out_kind = out_kind_w;

`ifndef ASSERT_OFF
	// The front end never pushes a job into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("job pushed into full queue");

	// A bank being handed back is never the bank being written
	a_bank_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rel.valid) |-> (wr_addr[IDX_W] != rel.bank))
		else $error("payload write into a bank still in delivery");

	// Payload bytes never close a reply sequence
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind_w == KIND_DATA) |-> !last)
		else $error("payload byte marked last");
`endif

endmodule

`default_nettype wire
